FILE: design/cmc_pkg.sv
// ---------------------------------------------------------------------------
// Complex mixed convolver package
// Shared sizes, field positions, codes and control types of the convolver.
// ---------------------------------------------------------------------------
package cmc_pkg;

  // Sizing of the tap and history stores and of the samples.
  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // Fixed field widths.
  localparam int TIDX_W = 5;
  localparam int KLEN_W = 6;
  localparam int ACC_W  = 40;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 1;

  // Input item tdata layout, lowest bit first.
  localparam int IN_IDX_LSB = 0;
  localparam int IN_RE_LSB  = IN_IDX_LSB + TIDX_W;
  localparam int IN_IM_LSB  = IN_RE_LSB + SAMPLE_BITS;
  localparam int IN_CLR_BIT = IN_IM_LSB + SAMPLE_BITS;
  localparam int IN_USED_W  = IN_CLR_BIT + 1;
  localparam int IN_W       = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_W      = 2 * ACC_W;

  // Item kinds carried in tuser.
  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KERNEL_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COMPLEX = 2'd1;
  localparam logic [1:0] CFG_KERNEL_COMPLEX = 2'd2;
  localparam logic [1:0] CFG_OUTPUT_COMPLEX = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_HOLD
  } seq_state_t;

  // Control that travels with each multiply-accumulate beat.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Operands of one beat.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] xr;
    logic signed [SAMPLE_BITS-1:0] xi;
    logic signed [SAMPLE_BITS-1:0] kr;
    logic signed [SAMPLE_BITS-1:0] ki;
  } mac_opd_t;

endpackage

FILE: design/cmc_ram.sv
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cmc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cmc_mac.sv
// ---------------------------------------------------------------------------
// Complex multiply-accumulate unit
// Pipelined complex product of one sample and one tap per beat, summed into
// 40-bit real and imaginary accumulators over a run of beats.
// ---------------------------------------------------------------------------
module cmc_mac
  import cmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  mac_opd_t                opd,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im
);

  mac_ctl_t                  s1_ctl;
  mac_ctl_t                  s2_ctl;
  logic signed [PROD_W-1:0]  p_rr;
  logic signed [PROD_W-1:0]  p_ii;
  logic signed [PROD_W-1:0]  p_ri;
  logic signed [PROD_W-1:0]  p_ir;
  logic signed [SUM_W-1:0]   sum_re;
  logic signed [SUM_W-1:0]   sum_im;
  logic signed [ACC_W-1:0]   acc_re_base;
  logic signed [ACC_W-1:0]   acc_im_base;

  // Control pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      done   <= 1'b0;
    end else begin
      s1_ctl <= ctl;
      s2_ctl <= s1_ctl;
      done   <= s2_ctl.vld && s2_ctl.last;
    end
  end

  // Stage 1: the four partial products.
  always_ff @(posedge clk) begin
    p_rr <= opd.xr * opd.kr;
    p_ii <= opd.xi * opd.ki;
    p_ri <= opd.xr * opd.ki;
    p_ir <= opd.xi * opd.kr;
  end

  // Stage 2: combine into the complex product.
  always_ff @(posedge clk) begin
    sum_re <= SUM_W'(p_rr) - SUM_W'(p_ii);
    sum_im <= SUM_W'(p_ri) + SUM_W'(p_ir);
  end

  // Stage 3: accumulate, restarting on the first beat of a run.
  assign acc_re_base = s2_ctl.first ? '0 : acc_re;
  assign acc_im_base = s2_ctl.first ? '0 : acc_im;

  always_ff @(posedge clk) begin
    if (s2_ctl.vld) begin
      acc_re <= acc_re_base + ACC_W'(sum_re);
      acc_im <= acc_im_base + ACC_W'(sum_im);
    end
  end

  // Done follows a closing beat: it is raised only after a valid last beat
  // has reached the accumulator stage.
  a_done_follows_beat : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s2_ctl.vld) && $past(s2_ctl.last))
    else $error("accumulator done without a closing beat");

  a_stage_order : assert property (@(posedge clk) disable iff (rst)
    s1_ctl.vld |=> s2_ctl.vld)
    else $error("beat lost between product and sum stages");

  a_single_done : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

FILE: design/complex_mixed_convolver.sv
// ---------------------------------------------------------------------------
// Complex mixed convolver
// Streaming FIR convolution of Q1.15 samples with loadable Q1.15 taps, in
// complex or real modes, with 40-bit full-precision sums.
// ---------------------------------------------------------------------------
// A tap-load item gives no result. For a sample item, the sequencer issues
// one tap per cycle to a single shared complex multiply-accumulate unit;
// each beat passes the read, product, sum and accumulate stages, and the
// final sum is then loaded into the output register. The input side is held
// off while a sample is in progress and is ready again in the cycle after the
// result is loaded. A result waiting in the output register does not stop the
// next item from being accepted, but that item's sum then waits for the output
// register, and the input stays held off until the older result is taken.
// Taps that were never loaded read as undefined, so load every tap below
// kernel_length before sending samples. The history is cleared at reset and
// by the clear flag of a sample item.
// ---------------------------------------------------------------------------
module complex_mixed_convolver
  import cmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input item stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  // s_tdata: tap_index[4:0], value_re[20:5], value_im[36:21],
  //          clear_history[37], zero fill above
  input  logic [IN_W-1:0]    s_tdata,
  // s_tuser: req_type[0]
  input  logic               s_tuser,
  // Result item stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata: out_re[39:0], out_im[79:40]
  output logic [OUT_W-1:0]   m_tdata,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [KLEN_W-1:0]  cfg_data
);

  seq_state_t               state;
  seq_state_t               state_next;
  logic                     issue;
  logic                     load_out;

  logic [KLEN_W-1:0]        kernel_length;
  logic                     sample_complex;
  logic                     kernel_complex;
  logic                     output_complex;

  logic                     accept;
  logic                     sample_acc;
  logic                     tap_we;
  logic [TIDX_W-1:0]        in_tap_index;
  logic [SAMPLE_BITS-1:0]   in_re;
  logic [SAMPLE_BITS-1:0]   in_im;
  logic                     in_clr;

  logic [IDX_W-1:0]         newest;
  logic [IDX_W-1:0]         newest_next;
  logic [MAX_TAPS-1:0]      hist_vld;
  logic [IDX_W-1:0]         cnt;
  logic [IDX_W-1:0]         last_cnt;
  logic [IDX_W:0]           slot_wrap;
  logic [IDX_W-1:0]         rd_slot;

  logic [PROD_W-1:0]        hist_rdata;
  logic [PROD_W-1:0]        tap_rdata;
  mac_ctl_t                 rd_ctl;
  logic                     rd_use;
  mac_opd_t                 opd;

  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_re;
  logic signed [ACC_W-1:0]  mac_im;

  // Input item fields.
  assign in_tap_index = s_tdata[IN_IDX_LSB +: TIDX_W];
  assign in_re        = s_tdata[IN_RE_LSB +: SAMPLE_BITS];
  assign in_im        = s_tdata[IN_IM_LSB +: SAMPLE_BITS];
  assign in_clr       = s_tdata[IN_CLR_BIT];

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign sample_acc = accept && (s_tuser == REQ_SAMPLE);
  assign tap_we     = accept && (s_tuser == REQ_TAP) && (32'(in_tap_index) < MAX_TAPS);

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_length  <= KLEN_W'(1);
      sample_complex <= 1'b0;
      kernel_complex <= 1'b0;
      output_complex <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KERNEL_LENGTH:  kernel_length  <= cfg_data;
        CFG_SAMPLE_COMPLEX: sample_complex <= cfg_data[0];
        CFG_KERNEL_COMPLEX: kernel_complex <= cfg_data[0];
        CFG_OUTPUT_COMPLEX: output_complex <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Index of the final beat: one beat even for a zero length, taps capped.
  always_comb begin
    if (kernel_length == '0) begin
      last_cnt = '0;
    end else if (32'(kernel_length) >= MAX_TAPS) begin
      last_cnt = IDX_W'(MAX_TAPS - 1);
    end else begin
      last_cnt = IDX_W'(kernel_length - KLEN_W'(1));
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (sample_acc) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        issue = 1'b1;
        if (cnt == last_cnt) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Tap counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + IDX_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  // Circular history pointer and per-slot valid bits.
  assign newest_next = (32'(newest) == MAX_TAPS - 1) ? '0 : newest + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      newest   <= '0;
      hist_vld <= '0;
    end else if (sample_acc) begin
      newest   <= newest_next;
      hist_vld <= (in_clr ? '0 : hist_vld) | (MAX_TAPS'(1) << newest_next);
    end
  end

  // History slot of tap cnt: newest minus cnt, modulo the store depth.
  assign slot_wrap = {1'b0, newest} + (IDX_W + 1)'(MAX_TAPS) - {1'b0, cnt};
  assign rd_slot   = (newest >= cnt) ? (newest - cnt) : slot_wrap[IDX_W-1:0];

  // History and tap stores, real part low and imaginary part high.
  cmc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (PROD_W),
    .AW    (IDX_W)
  ) u_hist (
    .clk   (clk),
    .we    (sample_acc),
    .waddr (newest_next),
    .wdata ({in_im, in_re}),
    .raddr (rd_slot),
    .rdata (hist_rdata)
  );

  cmc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (PROD_W),
    .AW    (IDX_W)
  ) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (IDX_W'(in_tap_index)),
    .wdata ({in_im, in_re}),
    .raddr (cnt),
    .rdata (tap_rdata)
  );

  // Beat control aligned with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
      rd_use <= 1'b0;
    end else begin
      rd_ctl.vld   <= issue;
      rd_ctl.first <= (cnt == '0);
      rd_ctl.last  <= (cnt == last_cnt);
      rd_use       <= hist_vld[rd_slot] && (kernel_length != '0);
    end
  end

  // Mode masking: an operand's imaginary part only counts in complex output
  // with that operand complex; empty history slots contribute zero.
  always_comb begin
    opd.xr = rd_use ? hist_rdata[SAMPLE_BITS-1:0] : '0;
    opd.xi = (rd_use && output_complex && sample_complex) ?
             hist_rdata[PROD_W-1:SAMPLE_BITS] : '0;
    opd.kr = tap_rdata[SAMPLE_BITS-1:0];
    opd.ki = (output_complex && kernel_complex) ? tap_rdata[PROD_W-1:SAMPLE_BITS] : '0;
  end

  cmc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (rd_ctl),
    .opd    (opd),
    .done   (mac_done),
    .acc_re (mac_re),
    .acc_im (mac_im)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {mac_im, mac_re};
    end
  end

  a_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_WAIT)
    else $error("accumulator finished outside the wait state");

  a_beats_in_run : assert property (@(posedge clk) disable iff (rst)
    rd_ctl.vld |-> (state == S_RUN || state == S_WAIT))
    else $error("read beat outside a sample computation");

  a_sample_starts : assert property (@(posedge clk) disable iff (rst)
    sample_acc |=> (state == S_RUN && cnt == '0 && hist_vld[newest]))
    else $error("sample item did not start a run with its slot valid");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
